### design/aes256_pkg.sv
// ----------------------------------------------------------------------------
// aes256_pkg
// Shared types, constants and byte functions for the AES-256 engine.
// ----------------------------------------------------------------------------
package aes256_pkg;

    localparam int NUM_ROUNDS = 14;
    localparam int NUM_ROWS   = NUM_ROUNDS + 1;
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 3'd6;

    localparam logic [7:0] GF_POLY   = 8'h1b;
    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef struct packed {
        logic init;   // key add only
        logic last;   // final round, no column mix
    } rnd_ctl_t;

    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_TBL[{~b, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

### design/aes256_round.sv
// ----------------------------------------------------------------------------
// aes256_round
// One AES round: SubBytes, ShiftRows, MixColumns (not last), AddRoundKey.
// ----------------------------------------------------------------------------
module aes256_round (
    input  logic [127:0]         st_in,
    input  logic [127:0]         rk,
    input  aes256_pkg::rnd_ctl_t ctl,
    output logic [127:0]         st_out
);
    import aes256_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] pre;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = st_in[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4*c+r] = sbox(s[4*((c+r)%4)+r]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
            m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
        end
        for (int i = 0; i < 16; i++)
        begin
            pre[127-8*i -: 8] = ctl.last ? t[i] : m[i];
        end
        st_out = (ctl.init ? st_in : pre) ^ rk;
    end

endmodule

### design/aes256_ecb_cbc_encrypt_top.sv
// ----------------------------------------------------------------------------
// aes256_ecb_cbc_encrypt_top
// AES-256 block encryption, ECB or CBC, round keys held in a 15-row memory.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one 128-bit plaintext block per
//    transfer. first_block=1 starts a message: the key schedule is rebuilt
//    from the key registers and CBC chains from the IV.
//  - Output channel (out_valid / out_stall): one ciphertext block per input.
//  - Config port (cfg_we / cfg_index / cfg_data): write only while idle.
//    Key and IV changes apply at the next first block.
// Timing:
//  - Key schedule: one 128-bit round-key row written per cycle.
//  - Encryption: one round per cycle through the single round unit,
//    held in the last round while the output is blocked; each round key
//    is read from memory in the cycle before its round. A first block runs
//    the key schedule before its rounds. Blocks are taken one at a time.
//  - The next block is taken while a result waits in the output register;
//    if that result is still stalled when the next one finishes, the engine
//    holds in its last round until the output register frees.
// Reset: clears config registers, chaining value and control; round-key
//  memory is not cleared and must be filled by a first block before use.
// ----------------------------------------------------------------------------
module aes256_ecb_cbc_encrypt_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [aes256_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [63:0]                      block_high,
    input  logic [63:0]                      block_low,
    input  logic                             first_block,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [63:0]                      cipher_high,
    output logic [63:0]                      cipher_low
);
    import aes256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXPAND = 3'b010,
        ST_ROUND  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] cnt_reg, cnt_next;

    logic [63:0]  key_reg [4];
    logic [63:0]  iv_hi_reg, iv_lo_reg;
    logic         mode_reg;
    logic [127:0] chain_reg;
    logic [127:0] blk_reg;
    logic [127:0] st_reg;
    logic         out_valid_reg;
    logic [127:0] out_reg;

    // key schedule window: the last eight words
    logic [31:0]  win_reg [8];
    logic [7:0]   rcon_reg;

    // round-key memory
    logic [127:0]     rk_mem [NUM_ROWS];
    logic [127:0]     rk_rdata_reg;
    logic             rk_we, rk_re;
    logic [ROW_W-1:0] rk_raddr;
    logic [127:0]     rk_wdata;

    logic         accept, adv, last_cnt;
    logic [31:0]  kt, n0, n1, n2, n3;
    logic [127:0] chain_sel;
    rnd_ctl_t     rctl;
    logic [127:0] rnd_out;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROUNDS);

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign adv      = !out_valid_reg || !out_stall;
    assign last_cnt = (cnt_reg == LAST_ROW);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            iv_hi_reg <= '0;
            iv_lo_reg <= '0;
            mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_0:      key_reg[0] <= cfg_data;
                REG_KEY_1:      key_reg[1] <= cfg_data;
                REG_KEY_2:      key_reg[2] <= cfg_data;
                REG_KEY_3:      key_reg[3] <= cfg_data;
                REG_IV_HIGH:    iv_hi_reg  <= cfg_data;
                REG_IV_LOW:     iv_lo_reg  <= cfg_data;
                REG_CHAIN_MODE: mode_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // key expansion: four words per row; even rows rotate and add rcon
    always_comb
    begin
        if (!cnt_reg[0])
        begin
            kt = sub_word({win_reg[7][23:0], win_reg[7][31:24]}) ^ {rcon_reg, 24'h0};
        end
        else
        begin
            kt = sub_word(win_reg[7]);
        end
        n0 = win_reg[0] ^ kt;
        n1 = win_reg[1] ^ n0;
        n2 = win_reg[2] ^ n1;
        n3 = win_reg[3] ^ n2;
        case (cnt_reg)
            ROW_W'(0): rk_wdata = {key_reg[0], key_reg[1]};
            ROW_W'(1): rk_wdata = {key_reg[2], key_reg[3]};
            default:   rk_wdata = {n0, n1, n2, n3};
        endcase
    end

    assign rk_we    = (state_reg == ST_EXPAND);
    assign rk_re    = (accept && !first_block)
                   || ((state_reg == ST_EXPAND) && last_cnt)
                   || ((state_reg == ST_ROUND) && !last_cnt);
    assign rk_raddr = (state_reg == ST_ROUND) ? cnt_reg + ROW_W'(1) : '0;

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[cnt_reg] <= rk_wdata;
        end
        if (rk_re)
        begin
            rk_rdata_reg <= rk_mem[rk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && first_block)
        begin
            win_reg[0] <= key_reg[0][63:32];
            win_reg[1] <= key_reg[0][31:0];
            win_reg[2] <= key_reg[1][63:32];
            win_reg[3] <= key_reg[1][31:0];
            win_reg[4] <= key_reg[2][63:32];
            win_reg[5] <= key_reg[2][31:0];
            win_reg[6] <= key_reg[3][63:32];
            win_reg[7] <= key_reg[3][31:0];
            rcon_reg   <= RCON_INIT;
        end
        else if ((state_reg == ST_EXPAND) && (cnt_reg > ROW_W'(1)))
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= win_reg[i+4];
            end
            win_reg[4] <= n0;
            win_reg[5] <= n1;
            win_reg[6] <= n2;
            win_reg[7] <= n3;
            if (!cnt_reg[0])
            begin
                rcon_reg <= xtime(rcon_reg);
            end
        end
    end

    // input block with chaining applied
    assign chain_sel = first_block ? {iv_hi_reg, iv_lo_reg} : chain_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg <= {block_high, block_low} ^ (mode_reg ? chain_sel : 128'h0);
        end
    end

    // round datapath
    assign rctl.init = (cnt_reg == '0);
    assign rctl.last = last_cnt;

    aes256_round u_round (
        .st_in  (rctl.init ? blk_reg : st_reg),
        .rk     (rk_rdata_reg),
        .ctl    (rctl),
        .st_out (rnd_out)
    );

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_ROUND) && !last_cnt)
        begin
            st_reg <= rnd_out;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = first_block ? ST_EXPAND : ST_ROUND;
                end
            end
            ST_EXPAND:
            begin
                cnt_next = cnt_reg + ROW_W'(1);
                if (last_cnt)
                begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                end
            end
            ST_ROUND:
            begin
                if (!last_cnt)
                begin
                    cnt_next = cnt_reg + ROW_W'(1);
                end
                else if (adv)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == ST_ROUND) && last_cnt && adv)
            begin
                out_valid_reg <= 1'b1;
                chain_reg     <= rnd_out;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_ROUND) && last_cnt && adv)
        begin
            out_reg <= rnd_out;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_high = out_reg[127:64];
    assign cipher_low  = out_reg[63:0];

    // checks
    a_expand_to_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPAND) && last_cnt |=> (state_reg == ST_ROUND) && (cnt_reg == '0))
        else $error("key schedule did not hand over to round 0");

    a_hold_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && last_cnt && !adv
        |=> (state_reg == ST_ROUND) && last_cnt && $stable(rk_rdata_reg) && $stable(st_reg))
        else $error("last round not held while output blocked");

    a_result_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && last_cnt && adv
        |=> out_valid_reg && (state_reg == ST_IDLE) && (chain_reg == out_reg))
        else $error("result not registered with chaining value");

endmodule

### test/aes256_ecb_cbc_encrypt_top_tb.sv
// ----------------------------------------------------------------------------
// aes256_ecb_cbc_encrypt_top_tb
// Self-checking bench for the AES-256 ECB/CBC encryption engine.
// A directed table (reset key, standard key vector, extremes, mode switches
// inside a message) is followed by random messages under several key, IV and
// mode settings, compared with an in-bench AES-256 model or typed-in values.
// ----------------------------------------------------------------------------
module aes256_ecb_cbc_encrypt_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes256_pkg::*;

    localparam int QUIET_LIMIT = 5000;  // cycles with no transfer on either side
    localparam int SETTLE_CYC  = 40;    // longer than a key schedule plus all rounds
    localparam int HOLD_CYC    = 300;   // long receiver hold-off
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_ITEMS = 250;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // no register here

    localparam logic [2047:0] SBOX_BYTES = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_t;

    typedef struct {
        int          phase;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        first;
        logic        known;   // expected value typed in below
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } vec_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [63:0]          block_high;
    logic [63:0]          block_low;
    logic                 first_block;
    logic                 out_valid;
    logic                 out_stall;
    logic [63:0]          cipher_high;
    logic [63:0]          cipher_low;

    aes256_ecb_cbc_encrypt_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .block_high  (block_high),
        .block_low   (block_low),
        .first_block (first_block),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cipher_high (cipher_high),
        .cipher_low  (cipher_low)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the engine: registers, round keys, chaining value
    // ------------------------------------------------------------------
    logic [63:0]  sh_key [4];
    logic [63:0]  sh_iv_hi;
    logic [63:0]  sh_iv_lo;
    logic         sh_cbc;
    logic [127:0] sh_round_key [NUM_ROUNDS+1];
    logic [63:0]  sh_chain_hi;
    logic [63:0]  sh_chain_lo;

    cipher_t cipher_fifo [$];

    int  n_sent;
    int  n_checked;
    int  n_errors;
    int  n_cbc;
    int  n_first;
    int  quiet;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  rx_hold_req;

    function automatic logic [7:0] sub_b(input logic [7:0] b);
        return SBOX_BYTES[2047 - 8 * b -: 8];
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_w(input logic [31:0] w);
        return {sub_b(w[31:24]), sub_b(w[23:16]), sub_b(w[15:8]), sub_b(w[7:0])};
    endfunction

    // AES-256 key schedule from the shadow key registers
    task automatic expand_round_keys();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            w[i] = i[0] ? sh_key[i/2][31:0] : sh_key[i/2][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i-1];
            if (i % 8 == 0)
            begin
                t  = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end
            else if (i % 8 == 4)
                t = sub_w(t);
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r <= NUM_ROUNDS; r++)
            sh_round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] encipher_block(input logic [127:0] pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] blk;
        blk = pt ^ sh_round_key[0];
        for (int r = 1; r <= NUM_ROUNDS; r++)
        begin
            for (int i = 0; i < 16; i++)
                s[i] = blk[127 - 8*i -: 8];
            // byte substitution and row shift
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    t[4*c + w] = sub_b(s[4*((c + w) & 3) + w]);
            if (r < NUM_ROUNDS)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    t[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
                    t[4*c+1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
                    t[4*c+2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
                    t[4*c+3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
                end
            for (int i = 0; i < 16; i++)
                blk[127 - 8*i -: 8] = t[i];
            blk = blk ^ sh_round_key[r];
        end
        return blk;
    endfunction

    // Advance the shadow state by one accepted block; returns its ciphertext
    task automatic predict_cipher(input logic [63:0] hi, input logic [63:0] lo,
                                  input logic first, output cipher_t ct);
        logic [127:0] pt;
        logic [127:0] res;
        logic [127:0] chain;
        chain = {sh_chain_hi, sh_chain_lo};
        if (first)
        begin
            expand_round_keys();
            chain = {sh_iv_hi, sh_iv_lo};
        end
        pt  = sh_cbc ? ({hi, lo} ^ chain) : {hi, lo};
        res = encipher_block(pt);
        sh_chain_hi = res[127:64];
        sh_chain_lo = res[63:0];
        ct.hi = res[127:64];
        ct.lo = res[63:0];
    endtask

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Any transfer on either side counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     QUIET_LIMIT, cipher_fifo.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: one expectation consumed per output transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cipher_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_fifo.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR %0t: unexpected result %h_%h", $realtime,
                             cipher_high, cipher_low);
            end
            else
            begin
                want = cipher_fifo.pop_front();
                n_checked++;
                if (cipher_high !== want.hi || cipher_low !== want.lo)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR %0t: result %0d exp %h_%h got %h_%h",
                                 $realtime, n_checked, want.hi, want.lo,
                                 cipher_high, cipher_low);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge clk);
                rx_hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Register write; the caller lowers cfg_we after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_KEY_0:      sh_key[0] = val;
            REG_KEY_1:      sh_key[1] = val;
            REG_KEY_2:      sh_key[2] = val;
            REG_KEY_3:      sh_key[3] = val;
            REG_IV_HIGH:    sh_iv_hi  = val;
            REG_IV_LOW:     sh_iv_lo  = val;
            REG_CHAIN_MODE: sh_cbc    = val[0];
            default:        ;  // unmapped index, ignored
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] ivh, input logic [63:0] ivl,
                             input logic [63:0] mode);
        write_reg(REG_KEY_0, k0);
        write_reg(REG_KEY_1, k1);
        write_reg(REG_KEY_2, k2);
        write_reg(REG_KEY_3, k3);
        write_reg(REG_IV_HIGH, ivh);
        write_reg(REG_IV_LOW, ivl);
        write_reg(REG_CHAIN_MODE, mode);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every result is back, then let the engine settle
    task automatic drain();
        in_valid <= 1'b0;
        while (cipher_fifo.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // One input transfer; valid stays high into the next call unless a gap
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic first, input logic known,
                              input logic [63:0] ehi, input logic [63:0] elo);
        cipher_t ct;
        in_valid    <= 1'b1;
        block_high  <= hi;
        block_low   <= lo;
        first_block <= first;
        do
            @(posedge clk);
        while (in_stall);
        predict_cipher(hi, lo, first, ct);
        if (known)
        begin
            ct.hi = ehi;
            ct.lo = elo;
        end
        cipher_fifo.push_back(ct);
        n_sent++;
        n_cbc   += sh_cbc;
        n_first += first;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Directed table. Phase 0 runs on reset registers (zero key, ECB);
    // phase 1 uses the standard AES-256 test key; phase 2 turns on CBC in
    // the middle of a message; phase 3 uses an all-ones key.
    vec_t dir_tbl [] = '{
        '{0, 64'h0, 64'h0, 1'b1, 1'b1, 64'hdc95c078a2408989, 64'had48a21492842087},
        '{0, '1, '1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
             64'h8ea2b7ca516745bf, 64'heafc49904b496089},
        '{1, '1, '1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1, 64'h8000000000000000, 64'h0000000000000001, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 1'b0, 64'h0, 64'h0},
        // CBC picks up the last ECB ciphertext, key change waits for first
        '{2, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0, 64'h0, 64'h0},
        '{2, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{2, '1, '1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{2, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{2, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 1'b0, 64'h0, 64'h0},
        '{3, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{3, '1, '1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{3, 64'h0, '1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{3, '1, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0}
    };

    initial
    begin
        int cur_phase;
        int sent_in_phase;
        int msg_len;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        block_high  = '0;
        block_low   = '0;
        first_block = 1'b0;
        out_stall   = 1'b0;
        quiet       = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_errors    = 0;
        n_cbc       = 0;
        n_first     = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        rx_hold_req = 1'b0;
        for (int i = 0; i < 4; i++)
            sh_key[i] = '0;
        sh_iv_hi    = '0;
        sh_iv_lo    = '0;
        sh_cbc      = 1'b0;
        sh_chain_hi = '0;
        sh_chain_lo = '0;
        foreach (sh_round_key[r])
            sh_round_key[r] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed table ----
        cur_phase = 0;
        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].phase != cur_phase)
            begin
                drain();
                cur_phase = dir_tbl[i].phase;
                case (cur_phase)
                    1: write_all(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                 64'h1011121314151617, 64'h18191a1b1c1d1e1f,
                                 '1, '1, 64'h0);
                    2: write_all('1, '1, '1, '1, '1, '1, '1);
                    default: write_all('1, '1, '1, '1, 64'h0, 64'h0,
                                       64'hfffffffffffffffe);
                endcase
            end
            send_block(dir_tbl[i].hi, dir_tbl[i].lo, dir_tbl[i].first,
                       dir_tbl[i].known, dir_tbl[i].exp_hi, dir_tbl[i].exp_lo);
        end

        // ---- random messages over several settings ----
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            if (ph == NUM_PHASES - 1)
            begin
                // final stretch runs at full rate on both sides
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                      {$urandom, $urandom});
            sent_in_phase = 0;
            msg_len = 0;
            while (sent_in_phase < PHASE_ITEMS)
            begin
                // long output hold-off while the sender keeps pushing
                if (ph == 1 && sent_in_phase == 100)
                    rx_hold_req = 1'b1;
                if (msg_len == 0)
                begin
                    msg_len = $urandom_range(1, 10);
                    // some messages carry on without a fresh start
                    send_block(rand64(), rand64(), $urandom_range(0, 5) != 0,
                               1'b0, 64'h0, 64'h0);
                end
                else
                    send_block(rand64(), rand64(), $urandom_range(0, 30) == 0,
                               1'b0, 64'h0, 64'h0);
                msg_len--;
                sent_in_phase++;
                // sender pause until the pipe is empty
                if (ph == 2 && sent_in_phase == 120)
                    drain();
            end
        end

        drain();
        $display("covered %0d blocks (%0d CBC, %0d message starts) over %0d settings,",
                 n_sent, n_cbc, n_first, NUM_PHASES + 4);
        $display("%0d results compared, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && cipher_fifo.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
design/aes256_pkg.sv
design/aes256_round.sv
design/aes256_ecb_cbc_encrypt_top.sv
test/aes256_ecb_cbc_encrypt_top_tb.sv
